[rtl/mms_pkg.sv]
// Package for the square matrix multiplier: field widths, mode codes and
// the control word that travels alongside the multiply-accumulate pipeline.
// No dependencies.
`timescale 1ns / 1ps

package mms_pkg;

    localparam int ELEM_W = 16;   // element width, signed
    localparam int PROD_W = 33;   // product element width, signed
    localparam int IDX_W  = 2;    // row / column field width
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD_LEFT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_RIGHT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE    = 2'd2;

    // one term of a dot product: first term restarts the sum, last closes it
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

[rtl/mms_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for both operand matrices. No dependencies.
`timescale 1ns / 1ps

module mms_ram #(
    parameter int DEPTH  = 9,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mms_mac.sv]
// Multiply-accumulate pipeline: registered 16x16 product, then a 33-bit
// running sum. Depends on mms_pkg for widths and the control word.
`timescale 1ns / 1ps

module mms_mac (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mms_pkg::t_mac_ctl                i_ctl,   // aligned with RAM address issue
    input  logic signed [mms_pkg::ELEM_W-1:0] i_a,    // RAM data, in the cycle after issue
    input  logic signed [mms_pkg::ELEM_W-1:0] i_b,
    output logic signed [mms_pkg::PROD_W-1:0] o_acc,
    output logic                             o_done
);

    mms_pkg::t_mac_ctl r_ctl1, r_ctl2;
    logic signed [2*mms_pkg::ELEM_W-1:0] r_prod;
    logic signed [mms_pkg::PROD_W-1:0]   r_acc;
    logic signed [mms_pkg::PROD_W-1:0]   w_prod_ext;
    logic                                r_done;

    assign w_prod_ext = mms_pkg::PROD_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_done <= r_ctl2.valid && r_ctl2.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_ctl2.valid) begin
            r_acc <= r_ctl2.first ? w_prod_ext : r_acc + w_prod_ext;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

[rtl/matrix_multiply_square.sv]
// Top level of the square signed matrix multiplier: command decode, element
// sequencer and output register. Depends on mms_pkg, mms_ram and mms_mac.
`timescale 1ns / 1ps

// Usage:
//   Input stream: each word carries a mode in tuser and row, column and a
//   16-bit signed value in tdata. Mode load-left / load-right writes one
//   element of the left / right matrix (out-of-range indexes are dropped);
//   mode compute emits the product left * right; mode 3 is dropped.
//   Output stream: one word per product element in row-major order, with
//   row, column and the exact 33-bit dot product; tlast marks the final one.
//   Load words are accepted back to back while the block is idle. A compute
//   word holds tready low until all DIM*DIM elements are done; each element
//   runs DIM operand reads through the single read port of each matrix RAM,
//   then RAM, multiply, accumulate and output register stages, and the next
//   element starts only once the previous sum is in the output register.
//   A stalled receiver holds the result in the output register; the
//   sequencer waits with the next finished sum until that register frees.
//   Reset clears the sequencer and output valid; matrix contents are
//   undefined until loaded.
module matrix_multiply_square #(
    parameter int DIM = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // row[1:0], col[3:2], elem_value[19:4]
    input  logic [1:0]  i_s_axis_tuser,   // mode[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // out_row[1:0], out_col[3:2], product_value[36:4]
    output logic        o_m_axis_tlast    // last
);

    localparam int CELLS = DIM * DIM;
    localparam int IW    = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int XW    = (IW > mms_pkg::IDX_W) ? IW : mms_pkg::IDX_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ISSUE = 3'b010,
        S_WAIT  = 3'b100
    } t_state;

    t_state r_state;
    logic [IW-1:0] r_i, r_j, r_k;
    logic          r_acc_valid;
    logic          r_out_valid;
    logic [mms_pkg::IDX_W-1:0]        r_out_row, r_out_col;
    logic signed [mms_pkg::PROD_W-1:0] r_out_value;
    logic                              r_out_last;

    // input decode
    logic                               w_accept;
    logic [mms_pkg::MODE_W-1:0]         w_mode;
    logic [mms_pkg::IDX_W-1:0]          w_row, w_col;
    logic [mms_pkg::ELEM_W-1:0]         w_value;
    logic                               w_in_range;
    logic [AW-1:0]                      w_waddr;
    logic                               w_we_left, w_we_right;

    // sequencer
    logic [AW-1:0]                      w_raddr_left, w_raddr_right;
    logic                               w_k_last, w_elem_last;
    mms_pkg::t_mac_ctl                  w_ctl;
    logic signed [mms_pkg::ELEM_W-1:0]  w_left_data, w_right_data;
    logic signed [mms_pkg::PROD_W-1:0]  w_acc;
    logic                               w_acc_done;
    logic                               w_out_free, w_load_out;
    logic [XW-1:0]                      w_i_ext, w_j_ext;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_mode   = i_s_axis_tuser;
    assign w_row    = i_s_axis_tdata[1:0];
    assign w_col    = i_s_axis_tdata[3:2];
    assign w_value  = i_s_axis_tdata[19:4];

    assign w_in_range = (32'(w_row) < 32'(DIM)) && (32'(w_col) < 32'(DIM));
    assign w_waddr    = AW'(AW'(w_row) * AW'(DIM) + AW'(w_col));
    assign w_we_left  = w_accept && w_in_range && (w_mode == mms_pkg::MODE_LOAD_LEFT);
    assign w_we_right = w_accept && w_in_range && (w_mode == mms_pkg::MODE_LOAD_RIGHT);

    // left walks row i across k, right walks column j down k
    assign w_raddr_left  = AW'(AW'(r_i) * AW'(DIM) + AW'(r_k));
    assign w_raddr_right = AW'(AW'(r_k) * AW'(DIM) + AW'(r_j));

    assign w_k_last    = (r_k == IW'(DIM - 1));
    assign w_elem_last = (r_i == IW'(DIM - 1)) && (r_j == IW'(DIM - 1));

    assign w_ctl.valid = (r_state == S_ISSUE);
    assign w_ctl.first = (r_k == '0);
    assign w_ctl.last  = w_k_last;

    mms_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (AW),
        .DATA_W (mms_pkg::ELEM_W)
    ) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_left),
        .i_waddr (w_waddr),
        .i_wdata (w_value),
        .i_raddr (w_raddr_left),
        .o_rdata (w_left_data)
    );

    mms_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (AW),
        .DATA_W (mms_pkg::ELEM_W)
    ) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_right),
        .i_waddr (w_waddr),
        .i_wdata (w_value),
        .i_raddr (w_raddr_right),
        .o_rdata (w_right_data)
    );

    mms_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (w_left_data),
        .i_b     (w_right_data),
        .o_acc   (w_acc),
        .o_done  (w_acc_done)
    );

    // move a finished sum out once the output register is empty or draining
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_load_out = r_acc_valid && w_out_free;

    assign w_i_ext = XW'(r_i);
    assign w_j_ext = XW'(r_j);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_acc_valid <= 1'b0;
        end else begin
            if (w_acc_done) begin
                r_acc_valid <= 1'b1;
            end else if (w_load_out) begin
                r_acc_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (w_mode == mms_pkg::MODE_COMPUTE)) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (w_k_last) begin
                        r_k     <= '0;
                        r_state <= S_WAIT;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_WAIT: begin
                    // hold indexes until the sum is handed to the output register
                    if (w_load_out) begin
                        if (w_elem_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ISSUE;
                            if (r_j == IW'(DIM - 1)) begin
                                r_j <= '0;
                                r_i <= r_i + 1'b1;
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_row   <= w_i_ext[mms_pkg::IDX_W-1:0];
            r_out_col   <= w_j_ext[mms_pkg::IDX_W-1:0];
            r_out_value <= w_acc;
            r_out_last  <= w_elem_last;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_value, r_out_col, r_out_row};
    assign o_m_axis_tlast  = r_out_last;

endmodule
